// ===== hw/rtl/jtl_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON token lexer package
// Shared token kinds, lexer modes, character codes and the result and queue
// entry types of the lexer core.
// ----------------------------------------------------------------------------
package jtl_pkg;

   localparam int JTL_QUEUE_DEPTH = 4;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_STR  = 2'd1;
   localparam logic [1:0] MODE_NUM  = 2'd2;
   localparam logic [1:0] MODE_SKIP = 2'd3;

   localparam logic [3:0] KIND_EOF     = 4'd0;
   localparam logic [3:0] KIND_STRING  = 4'd1;
   localparam logic [3:0] KIND_NUMBER  = 4'd2;
   localparam logic [3:0] KIND_BOOLEAN = 4'd3;
   localparam logic [3:0] KIND_NULL    = 4'd4;
   localparam logic [3:0] KIND_CUR_OP  = 4'd5;
   localparam logic [3:0] KIND_CUR_CL  = 4'd6;
   localparam logic [3:0] KIND_ARR_OP  = 4'd7;
   localparam logic [3:0] KIND_ARR_CL  = 4'd8;
   localparam logic [3:0] KIND_COLON   = 4'd9;
   localparam logic [3:0] KIND_COMMA   = 4'd10;
   localparam logic [3:0] KIND_UNKNOWN = 4'd11;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_F       = 8'h66;
   localparam logic [7:0] CHAR_T       = 8'h74;
   localparam logic [7:0] CHAR_N       = 8'h6E;
   localparam logic [7:0] CHAR_CUR_OP  = 8'h7B;
   localparam logic [7:0] CHAR_CUR_CL  = 8'h7D;
   localparam logic [7:0] CHAR_ARR_OP  = 8'h5B;
   localparam logic [7:0] CHAR_ARR_CL  = 8'h5D;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;

   localparam logic [2:0] SKIP_FALSE = 3'd4;
   localparam logic [2:0] SKIP_TRUE  = 3'd3;
   localparam logic [2:0] SKIP_NULL  = 3'd3;

   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] value_byte;
      logic       byte_valid;
      logic       token_end;
   } jtl_result_type;

   typedef struct packed {
      logic           two_results;
      jtl_result_type first;
      jtl_result_type second;
   } jtl_entry_type;

endpackage

// ===== hw/rtl/jtl_front.sv =====
// ----------------------------------------------------------------------------
// JSON token lexer front end
// Accepts one request per cycle when the queue has room, keeps the lexing
// mode and skip count, and puts a request's results, up to two, in one entry.
// ----------------------------------------------------------------------------
module jtl_front
   import jtl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tuser,
   output logic              push_valid,
   input  logic              push_ready,
   output jtl_entry_type     push_entry
);

   typedef struct packed {
      logic           has_result;
      jtl_result_type result;
      logic [1:0]     mode;
      logic [2:0]     skip;
   } jtl_idle_type;

   logic [1:0]     mode_ff;
   logic [1:0]     mode_in;
   logic [2:0]     skip_ff;
   logic [2:0]     skip_in;
   logic           accept;
   logic           has_result;
   jtl_entry_type  entry;
   jtl_idle_type   idle;
   logic [2:0]     skip_dec;

   function automatic jtl_result_type make_result(logic [3:0] kind, logic [7:0] value,
                                                 logic valid, logic last);
      jtl_result_type r;
      r.token_kind = kind;
      r.value_byte = value;
      r.byte_valid = valid;
      r.token_end  = last;
      return r;
   endfunction

   function automatic jtl_idle_type lex_idle(logic [7:0] b);
      jtl_idle_type o;
      o.has_result = 1'b1;
      o.result     = make_result(KIND_UNKNOWN, 8'h00, 1'b0, 1'b1);
      o.mode       = MODE_IDLE;
      o.skip       = 3'd0;
      if (b == CHAR_SPACE || b == CHAR_NEWLINE) begin
         o.has_result = 1'b0;
      end else if (b == CHAR_NUL) begin
         o.result = make_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
      end else if (b == CHAR_QUOTE) begin
         o.has_result = 1'b0;
         o.mode       = MODE_STR;
      end else if (b == CHAR_MINUS || (b >= CHAR_ZERO && b <= CHAR_NINE)) begin
         o.mode   = MODE_NUM;
         o.result = make_result(KIND_NUMBER, b, 1'b1, 1'b0);
      end else if (b == CHAR_F) begin
         o.mode   = MODE_SKIP;
         o.skip   = SKIP_FALSE;
         o.result = make_result(KIND_BOOLEAN, 8'h00, 1'b1, 1'b1);
      end else if (b == CHAR_T) begin
         o.mode   = MODE_SKIP;
         o.skip   = SKIP_TRUE;
         o.result = make_result(KIND_BOOLEAN, 8'h01, 1'b1, 1'b1);
      end else if (b == CHAR_N) begin
         o.mode   = MODE_SKIP;
         o.skip   = SKIP_NULL;
         o.result = make_result(KIND_NULL, 8'h00, 1'b0, 1'b1);
      end else if (b == CHAR_CUR_OP) begin
         o.result = make_result(KIND_CUR_OP, 8'h00, 1'b0, 1'b1);
      end else if (b == CHAR_CUR_CL) begin
         o.result = make_result(KIND_CUR_CL, 8'h00, 1'b0, 1'b1);
      end else if (b == CHAR_ARR_OP) begin
         o.result = make_result(KIND_ARR_OP, 8'h00, 1'b0, 1'b1);
      end else if (b == CHAR_ARR_CL) begin
         o.result = make_result(KIND_ARR_CL, 8'h00, 1'b0, 1'b1);
      end else if (b == CHAR_COLON) begin
         o.result = make_result(KIND_COLON, 8'h00, 1'b0, 1'b1);
      end else if (b == CHAR_COMMA) begin
         o.result = make_result(KIND_COMMA, 8'h00, 1'b0, 1'b1);
      end
      return o;
   endfunction

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;
   assign idle       = lex_idle(req_tdata);
   assign skip_dec   = skip_ff - 3'd1;

   always_comb begin
      has_result        = 1'b0;
      entry.two_results = 1'b0;
      entry.first       = make_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
      entry.second      = make_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
      mode_in           = mode_ff;
      skip_in           = skip_ff;
      if (req_tuser) begin
         has_result = 1'b1;
         mode_in    = MODE_IDLE;
         skip_in    = 3'd0;
         if (mode_ff == MODE_STR) begin
            entry.first       = make_result(KIND_STRING, 8'h00, 1'b0, 1'b1);
            entry.two_results = 1'b1;
         end else if (mode_ff == MODE_NUM) begin
            entry.first       = make_result(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
            entry.two_results = 1'b1;
         end
      end else begin
         case (mode_ff)
            MODE_STR: begin
               has_result = 1'b1;
               if (req_tdata == CHAR_QUOTE) begin
                  entry.first = make_result(KIND_STRING, 8'h00, 1'b0, 1'b1);
                  mode_in     = MODE_IDLE;
               end else begin
                  entry.first = make_result(KIND_STRING, req_tdata, 1'b1, 1'b0);
               end
            end
            MODE_NUM: begin
               has_result = 1'b1;
               if (req_tdata == CHAR_MINUS || req_tdata == CHAR_DOT ||
                   (req_tdata >= CHAR_ZERO && req_tdata <= CHAR_NINE)) begin
                  entry.first = make_result(KIND_NUMBER, req_tdata, 1'b1, 1'b0);
               end else begin
                  entry.first       = make_result(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
                  entry.second      = idle.result;
                  entry.two_results = idle.has_result;
                  mode_in           = idle.mode;
                  skip_in           = idle.skip;
               end
            end
            MODE_SKIP: begin
               if (skip_ff == 3'd0) begin
                  has_result  = idle.has_result;
                  entry.first = idle.result;
                  mode_in     = idle.mode;
                  skip_in     = idle.skip;
               end else begin
                  skip_in = skip_dec;
                  if (skip_dec == 3'd0) begin
                     mode_in = MODE_IDLE;
                  end
               end
            end
            default: begin
               has_result  = idle.has_result;
               entry.first = idle.result;
               mode_in     = idle.mode;
               skip_in     = idle.skip;
            end
         endcase
      end
   end

   assign push_valid = accept && has_result;
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         skip_ff <= 3'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         skip_ff <= skip_in;
      end
   end

endmodule

// ===== hw/rtl/jtl_queue.sv =====
// ----------------------------------------------------------------------------
// JSON token lexer entry queue
// Small first-in first-out queue of lexed entries between the front end and
// the result stage.
// ----------------------------------------------------------------------------
module jtl_queue
   import jtl_pkg::*;
#(
   parameter int Depth = JTL_QUEUE_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  jtl_entry_type     push_entry,
   output logic              pop_valid,
   input  logic              pop_ready,
   output jtl_entry_type     pop_entry
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCnt  = CountWidth'(Depth);

   jtl_entry_type         entries_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/jtl_back.sv =====
// ----------------------------------------------------------------------------
// JSON token lexer result stage
// Sends the one or two results of each queue entry out, one result per cycle
// while not stalled, via a registered output and a one-result holding stage.
// ----------------------------------------------------------------------------
module jtl_back
   import jtl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              entry_valid,
   output logic              entry_ready,
   input  jtl_entry_type     entry,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic [4:0]        rsp_tuser,
   output logic              rsp_tlast
);

   logic           out_valid_ff;
   logic           out_valid_in;
   jtl_result_type out_ff;
   jtl_result_type out_in;
   logic           pend_valid_ff;
   logic           pend_valid_in;
   jtl_result_type pend_ff;
   jtl_result_type pend_in;
   logic           out_free;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign entry_ready = out_free && !pend_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else if (entry_valid) begin
            out_valid_in  = 1'b1;
            out_in        = entry.first;
            pend_valid_in = entry.two_results;
            pend_in       = entry.second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.value_byte;
   assign rsp_tuser  = {out_ff.byte_valid, out_ff.token_kind};
   assign rsp_tlast  = out_ff.token_end;

endmodule

// ===== hw/rtl/json_token_lexer_core.sv =====
// ----------------------------------------------------------------------------
// JSON token lexer core
// Streaming lexer that turns a text byte stream into JSON token results.
// ----------------------------------------------------------------------------
// The core accepts one request per clock cycle while the queue has room: a
// text byte, or an end of input marker when req_tuser is high. The front end
// updates the lexing mode in the same cycle and writes the results of the
// request into an entry queue of QueueDepth entries, so requests keep flowing
// while the result side is stalled, until the queue is full. The result stage
// sends one result per cycle when not stalled, so a request that yields two
// results (a closed number followed by the next token, or end of input inside
// a string or number) uses the result port twice, and the result port sets
// the sustained rate. With the queue and result stage empty, the first result
// of a request reaches the result port through the queue and output register.
module json_token_lexer_core
   import jtl_pkg::*;
#(
   parameter int QueueDepth = JTL_QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] end_of_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] value_byte
   output logic [4:0] rsp_tuser,   // [3:0] token_kind, [4] byte_valid
   output logic       rsp_tlast    // token_end
);

   logic              push_valid;
   jtl_entry_type     push_entry;
   logic              queue_ready;
   logic              pop_valid;
   logic              pop_ready;
   jtl_entry_type     pop_entry;

   jtl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (queue_ready),
      .push_entry (push_entry)
   );

   jtl_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (queue_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   jtl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (pop_valid),
      .entry_ready (pop_ready),
      .entry       (pop_entry),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
